### rtl/fsk_slicer_bit_sync_phasing_macros.svh
// Assertion macros used by the top-level RTL file to check its own behavior.
`ifndef FSK_SLICER_BIT_SYNC_PHASING_MACROS_SVH
`define FSK_SLICER_BIT_SYNC_PHASING_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSBSP_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FSBSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/fsbsp_pkg.sv
`default_nettype none

package fsbsp_pkg;

    localparam int SPB_DEF        = 10;
    localparam int MAG_WIDTH_DEF  = 16;
    localparam int MAG_FIELD_BITS = 16;
    localparam int HIST_BITS      = 30;
    localparam int SYM_BITS       = 10;
    localparam int GATH_BITS      = 5;
    localparam int PHASE_COUNT    = 10;
    localparam int OUT_BITS       = 24;

    localparam logic [GATH_BITS-1:0] GATH_FULL = GATH_BITS'(30);
    localparam logic [GATH_BITS-1:0] GATH_HOLD = GATH_BITS'(29);
    localparam logic [GATH_BITS-1:0] GATH_SYM  = GATH_BITS'(10);

    typedef logic [HIST_BITS-1:0] fsbsp_pat_t;

    // Phasing patterns, oldest symbol in the upper bits.
    localparam fsbsp_pat_t PHASE_PAT [PHASE_COUNT] = '{
        {10'h2F9, 10'h3D9, 10'h2F9},
        {10'h3D9, 10'h2F9, 10'h1DA},
        {10'h2F9, 10'h1DA, 10'h2F9},
        {10'h1DA, 10'h2F9, 10'h2DA},
        {10'h2F9, 10'h2DA, 10'h2F9},
        {10'h2DA, 10'h2F9, 10'h0DB},
        {10'h2F9, 10'h0DB, 10'h2F9},
        {10'h0DB, 10'h2F9, 10'h35A},
        {10'h2F9, 10'h35A, 10'h2F9},
        {10'h35A, 10'h2F9, 10'h15B}
    };

    localparam logic [3:0] PHASE_OFF [PHASE_COUNT] = '{
        4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
    };

    // Declared from the highest bit down, so decision lands in bit 0.
    typedef struct packed {
        logic [SYM_BITS-1:0] symbol;
        logic                symbol_valid;
        logic [3:0]          phase_offset;
        logic                sync_found;
        logic                in_sync;
        logic                sampled_bit;
        logic                bit_strobe;
        logic                decision;
    } fsbsp_result_t;

    typedef struct packed {
        logic load;
        logic scan;
    } fsbsp_win_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } fsbsp_state_t;

endpackage

`default_nettype wire

### rtl/fsbsp_cell.sv
`default_nettype none

module fsbsp_cell #(
    parameter int MAG_WIDTH = fsbsp_pkg::MAG_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 shift_en,
    input  logic [MAG_WIDTH-1:0] mark_in,
    input  logic [MAG_WIDTH-1:0] space_in,
    output logic [MAG_WIDTH-1:0] mark_out,
    output logic [MAG_WIDTH-1:0] space_out
);

    logic [MAG_WIDTH-1:0] mark_reg;
    logic [MAG_WIDTH-1:0] mark_next;
    logic [MAG_WIDTH-1:0] space_reg;
    logic [MAG_WIDTH-1:0] space_next;

    always_comb begin
        mark_next  = shift_en ? mark_in : mark_reg;
        space_next = shift_en ? space_in : space_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mark_reg  <= '0;
            space_reg <= '0;
        end else begin
            mark_reg  <= mark_next;
            space_reg <= space_next;
        end
    end

    assign mark_out  = mark_reg;
    assign space_out = space_reg;

endmodule

`default_nettype wire

### rtl/fsbsp_window.sv
`default_nettype none

module fsbsp_window #(
    parameter int SAMPLES_PER_BIT = fsbsp_pkg::SPB_DEF,
    parameter int MAG_WIDTH       = fsbsp_pkg::MAG_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  fsbsp_pkg::fsbsp_win_ctrl_t  ctrl,
    input  logic [MAG_WIDTH-1:0]        mark_in,
    input  logic [MAG_WIDTH-1:0]        space_in,
    output logic [MAG_WIDTH-1:0]        env_mark,
    output logic [MAG_WIDTH-1:0]        env_space
);

    import fsbsp_pkg::*;

    localparam int WIN_LEN = 8 * SAMPLES_PER_BIT;

    logic [MAG_WIDTH-1:0] mark_chain  [WIN_LEN+1];
    logic [MAG_WIDTH-1:0] space_chain [WIN_LEN+1];
    logic                 shift_en;
    logic [MAG_WIDTH-1:0] env_mark_reg;
    logic [MAG_WIDTH-1:0] env_mark_next;
    logic [MAG_WIDTH-1:0] env_space_reg;
    logic [MAG_WIDTH-1:0] env_space_next;

    // A new sample pushes the oldest one out. A scan cycle rotates the chain
    // by one, so a full scan visits every cell and leaves the order unchanged.
    assign shift_en       = ctrl.load | ctrl.scan;
    assign mark_chain[0]  = ctrl.load ? mark_in : mark_chain[WIN_LEN];
    assign space_chain[0] = ctrl.load ? space_in : space_chain[WIN_LEN];

    for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
        fsbsp_cell #(
            .MAG_WIDTH (MAG_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .mark_in   (mark_chain[i]),
            .space_in  (space_chain[i]),
            .mark_out  (mark_chain[i+1]),
            .space_out (space_chain[i+1])
        );
    end

    always_comb begin
        env_mark_next  = env_mark_reg;
        env_space_next = env_space_reg;
        if (ctrl.load) begin
            env_mark_next  = '0;
            env_space_next = '0;
        end else if (ctrl.scan) begin
            if (mark_chain[WIN_LEN] > env_mark_reg) begin
                env_mark_next = mark_chain[WIN_LEN];
            end
            if (space_chain[WIN_LEN] > env_space_reg) begin
                env_space_next = space_chain[WIN_LEN];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_mark_reg  <= '0;
            env_space_reg <= '0;
        end else begin
            env_mark_reg  <= env_mark_next;
            env_space_reg <= env_space_next;
        end
    end

    assign env_mark  = env_mark_reg;
    assign env_space = env_space_reg;

endmodule

`default_nettype wire

### rtl/fsbsp_sync.sv
`default_nettype none

module fsbsp_sync #(
    parameter int SAMPLES_PER_BIT = fsbsp_pkg::SPB_DEF,
    parameter int MAG_WIDTH       = fsbsp_pkg::MAG_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       restart,
    input  logic [MAG_WIDTH-1:0]       mark,
    input  logic [MAG_WIDTH-1:0]       space,
    input  logic [MAG_WIDTH-1:0]       env_mark,
    input  logic [MAG_WIDTH-1:0]       env_space,
    output fsbsp_pkg::fsbsp_result_t   result
);

    import fsbsp_pkg::*;

    localparam int CW = $clog2(SAMPLES_PER_BIT) + 10;
    localparam int SW = MAG_WIDTH + 2;

    localparam logic signed [CW-1:0] CLK_RESET = CW'(-(SAMPLES_PER_BIT * 128));
    localparam logic signed [CW-1:0] CLK_STEP  = CW'(256);
    localparam logic signed [CW-1:0] CLK_MID   = CW'(SAMPLES_PER_BIT * 128 - 256);
    localparam logic signed [CW-1:0] CLK_BIT   = CW'(SAMPLES_PER_BIT * 256);

    logic                   prev_reg;
    logic                   prev_next;
    logic signed [CW-1:0]   clk_reg;
    logic signed [CW-1:0]   clk_next;
    logic [HIST_BITS-1:0]   hist_reg;
    logic [HIST_BITS-1:0]   hist_next;
    logic [GATH_BITS-1:0]   gath_reg;
    logic [GATH_BITS-1:0]   gath_next;
    logic                   locked_reg;
    logic                   locked_next;

    always_comb begin
        logic [SW-1:0]        lhs;
        logic [SW-1:0]        rhs;
        logic                 dec;
        logic signed [CW-1:0] c_edge;
        logic signed [CW-1:0] c_inc;
        logic                 strobe;
        logic                 match;
        logic [3:0]           moff;
        logic [HIST_BITS-1:0] hist_n;
        logic [GATH_BITS-1:0] gath_n;
        logic                 locked_n;
        logic                 found;
        logic                 symv;

        // Threshold correction: 2*mark - envM > 2*space - envS, moved to sums.
        lhs = SW'({mark, 1'b0}) + SW'(env_space);
        rhs = SW'({space, 1'b0}) + SW'(env_mark);
        dec = lhs > rhs;

        c_edge = (dec && !prev_reg) ? clk_reg - (clk_reg >>> 2) : clk_reg;
        c_inc  = c_edge + CLK_STEP;
        strobe = c_inc >= CLK_MID;

        match = 1'b0;
        moff  = '0;
        found = 1'b0;
        symv  = 1'b0;
        hist_n   = hist_reg;
        gath_n   = gath_reg;
        locked_n = locked_reg;

        if (strobe) begin
            hist_n = {hist_reg[HIST_BITS-2:0], dec};
            gath_n = gath_reg + GATH_BITS'(1);
            for (int i = PHASE_COUNT - 1; i >= 0; i--) begin
                if (hist_n == PHASE_PAT[i]) begin
                    match = 1'b1;
                    moff  = PHASE_OFF[i];
                end
            end
            if (!locked_reg) begin
                if (gath_n == GATH_FULL) begin
                    if (match) begin
                        locked_n = 1'b1;
                        gath_n   = '0;
                        found    = 1'b1;
                    end else begin
                        gath_n = GATH_HOLD;
                    end
                end
            end else if (gath_n == GATH_SYM) begin
                symv   = 1'b1;
                gath_n = '0;
            end
        end

        prev_next   = prev_reg;
        clk_next    = clk_reg;
        hist_next   = hist_reg;
        gath_next   = gath_reg;
        locked_next = locked_reg;

        result = '0;
        if (restart) begin
            clk_next        = CLK_RESET;
            hist_next       = '0;
            gath_next       = '0;
            locked_next     = 1'b0;
            result.decision = prev_reg;
        end else begin
            if (step) begin
                prev_next   = dec;
                clk_next    = strobe ? c_inc - CLK_BIT : c_inc;
                hist_next   = hist_n;
                gath_next   = gath_n;
                locked_next = locked_n;
            end
            result.decision     = dec;
            result.bit_strobe   = strobe;
            result.sampled_bit  = strobe & dec;
            result.in_sync      = locked_n;
            result.sync_found   = found;
            result.phase_offset = found ? moff : 4'd0;
            result.symbol_valid = symv;
            result.symbol       = hist_n[SYM_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= 1'b0;
            clk_reg    <= CLK_RESET;
            hist_reg   <= '0;
            gath_reg   <= '0;
            locked_reg <= 1'b0;
        end else begin
            prev_reg   <= prev_next;
            clk_reg    <= clk_next;
            hist_reg   <= hist_next;
            gath_reg   <= gath_next;
            locked_reg <= locked_next;
        end
    end

endmodule

`default_nettype wire

### rtl/fsk_slicer_bit_sync_phasing.sv
// A sample transaction is loaded into the window at the accepting edge, then the scan visits
// every cell for the envelope maxima, then the slice is registered once the output is free.
// A restart transaction goes from idle straight to the done state, with no scan.
// A new sample or restart is taken only in the idle state, after the last result is registered.
// Reset: aresetn, synchronous, active low, clears the envelope cells to zero, the clock
// counter to minus half a bit and the phasing state to hunting.
`default_nettype none
`include "fsk_slicer_bit_sync_phasing_macros.svh"

module fsk_slicer_bit_sync_phasing #(
    parameter int SAMPLES_PER_BIT = fsbsp_pkg::SPB_DEF,
    parameter int MAG_WIDTH       = fsbsp_pkg::MAG_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // mag_mark [15:0], mag_space [31:16]
    input  logic [31:0] s_tdata,
    // command [0]
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // decision, bit_strobe, sampled_bit, in_sync, sync_found, phase_offset [8:5],
    // symbol_valid [9], symbol [19:10], zero fill [23:20]
    output logic [23:0] m_tdata
);

    import fsbsp_pkg::*;

    localparam int WIN_LEN = 8 * SAMPLES_PER_BIT;
    localparam int CNT_W   = $clog2(WIN_LEN);
    localparam int IN_BITS = (MAG_WIDTH < MAG_FIELD_BITS) ? MAG_WIDTH : MAG_FIELD_BITS;
    localparam int RES_W   = $bits(fsbsp_result_t);

    fsbsp_state_t         state_reg;
    fsbsp_state_t         state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 cmd_reg;
    logic                 cmd_next;
    logic [MAG_WIDTH-1:0] mark_reg;
    logic [MAG_WIDTH-1:0] mark_next;
    logic [MAG_WIDTH-1:0] space_reg;
    logic [MAG_WIDTH-1:0] space_next;
    fsbsp_result_t        res_reg;
    fsbsp_result_t        res_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic                 in_accept;
    logic                 finish;
    logic [MAG_WIDTH-1:0] mark_in;
    logic [MAG_WIDTH-1:0] space_in;
    fsbsp_win_ctrl_t      win_ctrl;
    logic [MAG_WIDTH-1:0] env_mark;
    logic [MAG_WIDTH-1:0] env_space;
    fsbsp_result_t        sync_res;

    assign mark_in   = MAG_WIDTH'(s_tdata[IN_BITS-1:0]);
    assign space_in  = MAG_WIDTH'(s_tdata[MAG_FIELD_BITS +: IN_BITS]);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign finish    = (state_reg == ST_DONE) & (~out_valid_reg | m_tready);

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        mark_next      = mark_reg;
        space_next     = space_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        win_ctrl.load  = in_accept & ~s_tuser[0];
        win_ctrl.scan  = (state_reg == ST_SCAN);

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    cmd_next   = s_tuser[0];
                    mark_next  = mark_in;
                    space_next = space_in;
                    cnt_next   = CNT_W'(WIN_LEN - 1);
                    state_next = s_tuser[0] ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (finish) begin
                    res_next       = sync_res;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cmd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mark_reg  <= mark_next;
        space_reg <= space_next;
        res_reg   <= res_next;
    end

    fsbsp_window #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .MAG_WIDTH       (MAG_WIDTH)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .mark_in   (mark_in),
        .space_in  (space_in),
        .env_mark  (env_mark),
        .env_space (env_space)
    );

    fsbsp_sync #(
        .SAMPLES_PER_BIT (SAMPLES_PER_BIT),
        .MAG_WIDTH       (MAG_WIDTH)
    ) u_sync (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (finish & ~cmd_reg),
        .restart   (finish & cmd_reg),
        .mark      (mark_reg),
        .space     (space_reg),
        .env_mark  (env_mark),
        .env_space (env_space),
        .result    (sync_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_BITS - RES_W)'(0), res_reg};

    `FSBSP_ASSERT_SAME(a_found_locked, aclk, aresetn, m_tvalid && res_reg.sync_found,
        res_reg.in_sync)
    `FSBSP_ASSERT_SAME(a_symbol_on_strobe, aclk, aresetn, m_tvalid && res_reg.symbol_valid,
        res_reg.bit_strobe && res_reg.in_sync && !res_reg.sync_found)
    `FSBSP_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_accept, !s_tready)
    `FSBSP_ASSERT_SAME(a_restart_quiet, aclk, aresetn, finish && cmd_reg,
        sync_res.symbol == '0 && !sync_res.bit_strobe && !sync_res.in_sync)

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fsbsp_pkg::*;

    localparam int SPB = SPB_DEF;
    localparam int ENV_LEN = 8 * SPB;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TARGET_SAMPLES = 1400;
    localparam int DRAIN_CYCLES = 200;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] mark;
        logic [15:0] space;
    } sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [23:0] m_tdata;

    fsk_slicer_bit_sync_phasing #(
        .SAMPLES_PER_BIT(SPB_DEF),
        .MAG_WIDTH(MAG_WIDTH_DEF)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    sample_t sample_backlog[$];
    sample_t sample_script[$];
    fsbsp_result_t demod_results[$];
    sample_t sample_on_bus;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Demodulator state mirrored from the block.
    logic [15:0] mark_env[ENV_LEN];
    logic [15:0] space_env[ENV_LEN];
    int env_pos;
    logic prev_level;
    int bit_clock;
    logic [29:0] bit_hist;
    logic [4:0] bits_held;
    logic hunt_locked;

    function automatic logic [29:0] phasing_word(int idx);
        case (idx)
            0: phasing_word = {10'h2F9, 10'h3D9, 10'h2F9};
            1: phasing_word = {10'h3D9, 10'h2F9, 10'h1DA};
            2: phasing_word = {10'h2F9, 10'h1DA, 10'h2F9};
            3: phasing_word = {10'h1DA, 10'h2F9, 10'h2DA};
            4: phasing_word = {10'h2F9, 10'h2DA, 10'h2F9};
            5: phasing_word = {10'h2DA, 10'h2F9, 10'h0DB};
            6: phasing_word = {10'h2F9, 10'h0DB, 10'h2F9};
            7: phasing_word = {10'h0DB, 10'h2F9, 10'h35A};
            8: phasing_word = {10'h2F9, 10'h35A, 10'h2F9};
            default: phasing_word = {10'h35A, 10'h2F9, 10'h15B};
        endcase
    endfunction

    function automatic void restart_hunt();
        bit_clock = -SPB * 128;
        bit_hist = '0;
        bits_held = '0;
        hunt_locked = 1'b0;
    endfunction

    function automatic fsbsp_result_t demod_sample(sample_t smp);
        fsbsp_result_t res;
        logic [15:0] env_m;
        logic [15:0] env_s;
        logic level;
        int lhs;
        int rhs;
        res = '0;
        if (smp.cmd == CMD_RESTART) begin
            restart_hunt();
            res.decision = prev_level;
            return res;
        end
        mark_env[env_pos] = smp.mark;
        space_env[env_pos] = smp.space;
        env_pos = (env_pos == ENV_LEN - 1) ? 0 : env_pos + 1;
        env_m = '0;
        env_s = '0;
        for (int i = 0; i < ENV_LEN; i++) begin
            if (mark_env[i] > env_m) env_m = mark_env[i];
            if (space_env[i] > env_s) env_s = space_env[i];
        end
        lhs = 2 * int'(smp.mark) - int'(env_m);
        rhs = 2 * int'(smp.space) - int'(env_s);
        level = (lhs > rhs);
        // A rising data edge pulls the bit clock a quarter of the way toward zero.
        if (level && !prev_level) bit_clock = bit_clock - (bit_clock >>> 2);
        prev_level = level;
        bit_clock = bit_clock + 256;
        if (bit_clock >= SPB * 128 - 256) begin
            bit_clock = bit_clock - SPB * 256;
            res.bit_strobe = 1'b1;
            res.sampled_bit = level;
            bit_hist = {bit_hist[28:0], level};
            bits_held = bits_held + 5'd1;
            if (!hunt_locked) begin
                if (bits_held == 5'd30) begin
                    bits_held = 5'd29;
                    for (int i = 0; i < 10; i++) begin
                        if (!res.sync_found && bit_hist == phasing_word(i)) begin
                            hunt_locked = 1'b1;
                            bits_held = '0;
                            res.sync_found = 1'b1;
                            res.phase_offset = 4'(9 - i);
                        end
                    end
                end
            end else if (bits_held == 5'd10) begin
                res.symbol_valid = 1'b1;
                bits_held = '0;
            end
        end
        res.decision = level;
        res.in_sync = hunt_locked;
        res.symbol = bit_hist[9:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                demod_results = {demod_results, demod_sample(sample_on_bus)};
            end
            if (!s_tvalid || s_tready) begin
                if (sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    sample_on_bus = sample_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {sample_on_bus.space, sample_on_bus.mark};
                    s_tuser <= sample_on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string what);
        $display("mismatch at %0t ns: %s", $time, what);
        error_count++;
    endtask

    task automatic compare_field(string name, int got, int want);
        if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic check_result(fsbsp_result_t got);
        fsbsp_result_t want;
        if (demod_results.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
        end else begin
            want = demod_results.pop_front();
            compare_field("decision", int'(got.decision), int'(want.decision));
            compare_field("bit_strobe", int'(got.bit_strobe), int'(want.bit_strobe));
            compare_field("sampled_bit", int'(got.sampled_bit), int'(want.sampled_bit));
            compare_field("in_sync", int'(got.in_sync), int'(want.in_sync));
            compare_field("sync_found", int'(got.sync_found), int'(want.sync_found));
            compare_field("phase_offset", int'(got.phase_offset), int'(want.phase_offset));
            compare_field("symbol_valid", int'(got.symbol_valid), int'(want.symbol_valid));
            compare_field("symbol", int'(got.symbol), int'(want.symbol));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_result(fsbsp_result_t'(m_tdata[$bits(fsbsp_result_t)-1:0]));
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    task automatic add_sample(logic cmd, logic [15:0] mark, logic [15:0] space);
        sample_t smp;
        smp.cmd = cmd;
        smp.mark = mark;
        smp.space = space;
        sample_script = {sample_script, smp};
    endtask

    // One keyed bit, mostly a nominal bit period long with some timing jitter.
    task automatic add_bit(logic b, int amp_m, int amp_s);
        int len;
        int r;
        r = $urandom_range(99);
        len = (r < 5) ? SPB - 1 : (r < 10) ? SPB + 1 : SPB;
        for (int k = 0; k < len; k++) begin
            if (b) begin
                add_sample(CMD_SAMPLE, 16'(amp_m - $urandom_range(amp_m / 8)),
                           16'($urandom_range(amp_s / 16)));
            end else begin
                add_sample(CMD_SAMPLE, 16'($urandom_range(amp_m / 16)),
                           16'(amp_s - $urandom_range(amp_s / 8)));
            end
        end
    endtask

    // Dot preamble, phasing word, data symbols, then a restart to hunt again.
    // A broken frame cuts the phasing word short and goes straight on to the restart.
    task automatic add_frame(int pat_idx, bit broken);
        int amp_m;
        int amp_s;
        int lead;
        int nbits;
        int nsym;
        logic [29:0] word;
        logic [9:0] sym;
        amp_m = $urandom_range(65535, 8000);
        amp_s = $urandom_range(65535, 8000);
        lead = $urandom_range(8, 3);
        word = phasing_word(pat_idx);
        nbits = broken ? $urandom_range(29, 5) : 30;
        for (int k = 0; k < lead; k++) add_bit(~k[0], amp_m, amp_s);
        for (int j = 29; j >= 30 - nbits; j--) add_bit(word[j], amp_m, amp_s);
        if (!broken) begin
            nsym = $urandom_range(3, 1);
            for (int n = 0; n < nsym; n++) begin
                sym = 10'($urandom);
                for (int j = 9; j >= 0; j--) add_bit(sym[j], amp_m, amp_s);
            end
        end
        add_sample(CMD_RESTART, 16'($urandom), 16'($urandom));
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(40, 10);
        for (int k = 0; k < n; k++) begin
            add_sample(($urandom_range(15) == 0) ? CMD_RESTART : CMD_SAMPLE,
                       16'($urandom), 16'($urandom));
        end
    endtask

    task automatic drain_all();
        while (sample_backlog.size() != 0 || s_tvalid) @(negedge aclk);
        while (demod_results.size() != 0) @(negedge aclk);
    endtask

    initial begin
        int next_pat;
        int r;
        int chunk;
        int phase_idle[4];
        int phase_stall[4];
        for (int i = 0; i < ENV_LEN; i++) begin
            mark_env[i] = '0;
            space_env[i] = '0;
        end
        env_pos = 0;
        prev_level = 1'b0;
        restart_hunt();
        phase_idle = '{0, 66, 0, 37};
        phase_stall = '{0, 0, 66, 37};

        add_sample(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        add_sample(CMD_SAMPLE, 16'h0000, 16'hFFFF);
        add_sample(CMD_SAMPLE, 16'h0000, 16'h0000);
        add_sample(CMD_SAMPLE, 16'hFFFF, 16'hFFFF);
        add_sample(CMD_SAMPLE, 16'hAAAA, 16'h5555);
        add_sample(CMD_SAMPLE, 16'h5555, 16'hAAAA);
        add_sample(CMD_RESTART, 16'hFFFF, 16'hFFFF);
        add_sample(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        add_sample(CMD_SAMPLE, 16'hFFFF, 16'h0000);
        add_sample(CMD_RESTART, 16'h0000, 16'h0000);
        add_sample(CMD_SAMPLE, 16'h0001, 16'h0000);
        add_sample(CMD_SAMPLE, 16'h0000, 16'h0001);
        add_sample(CMD_SAMPLE, 16'h8000, 16'h7FFF);
        add_sample(CMD_SAMPLE, 16'hFFFF, 16'hFFFE);
        add_sample(CMD_SAMPLE, 16'h7FFF, 16'h8000);
        add_sample(CMD_RESTART, 16'h1234, 16'hFEDC);

        // Frames are long, so stop early enough that the total lands near the target.
        next_pat = $urandom_range(9);
        while (sample_script.size() < TARGET_SAMPLES - 250) begin
            r = $urandom_range(99);
            if (r < 75) begin
                add_frame(next_pat, 1'b0);
                next_pat = (next_pat + 1) % 10;
            end else if (r < 87) begin
                add_frame($urandom_range(9), 1'b1);
            end else begin
                add_noise();
            end
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        chunk = (sample_script.size() + 3) / 4;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int k = 0; k < chunk && sample_script.size() > 0; k++) begin
                sample_backlog = {sample_backlog, sample_script.pop_front()};
            end
            drain_all();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
